>>> hdl/multi_press_key_decoder_defines.svh
// Assertion helpers for the key decoder.
`ifndef MULTI_PRESS_KEY_DECODER_DEFINES_SVH
`define MULTI_PRESS_KEY_DECODER_DEFINES_SVH

// Same-cycle check, disabled while in reset.
`define MPKD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check that holds on the cycle after the trigger.
`define MPKD_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error(msg);

`endif

>>> hdl/mpkd_pkg.sv
`timescale 1ns / 1ps
package mpkd_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned LIMIT_W = 16;
    localparam int unsigned CODE_W  = 8;
    localparam int unsigned COUNT_W = 3;
    localparam int unsigned IDX_W   = 3;

    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 16;

    localparam logic [IDX_W-1:0] REG_PRESS_POL     = 3'd0;
    localparam logic [IDX_W-1:0] REG_DEBOUNCE      = 3'd1;
    localparam logic [IDX_W-1:0] REG_SHORT_PRESS   = 3'd2;
    localparam logic [IDX_W-1:0] REG_VERY_LONG     = 3'd3;
    localparam logic [IDX_W-1:0] REG_FIRE_GAP      = 3'd4;

    localparam logic [LIMIT_W-1:0] DEBOUNCE_RST    = 16'd30;
    localparam logic [LIMIT_W-1:0] SHORT_PRESS_RST = 16'd500;
    localparam logic [LIMIT_W-1:0] VERY_LONG_RST   = 16'd3000;
    localparam logic [LIMIT_W-1:0] FIRE_GAP_RST    = 16'd500;

    localparam logic [CODE_W-1:0] VERY_LONG_CODE = 8'hFF;
    localparam int unsigned       COUNT_SHIFT    = 5;

    typedef enum logic [5:0] {
        MODE_WAIT     = 6'b000001,
        MODE_DEB_DOWN = 6'b000010,
        MODE_DEB_UP   = 6'b000100,
        MODE_HELD     = 6'b001000,
        MODE_GAP      = 6'b010000,
        MODE_VLONG    = 6'b100000
    } mode_t;

    typedef struct packed {
        logic               press_pol;
        logic [LIMIT_W-1:0] debounce_ms;
        logic [LIMIT_W-1:0] short_press_ms;
        logic [LIMIT_W-1:0] very_long_press_ms;
        logic [LIMIT_W-1:0] fire_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic              take_value;
        logic [TIME_W-1:0] now_ms;
        logic              pin_level;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0] key_code;
        logic              fired;
    } result_t;

endpackage

>>> hdl/mpkd_core.sv
`timescale 1ns / 1ps
`include "multi_press_key_decoder_defines.svh"
module mpkd_core
    import mpkd_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    en,
    input  cfg_t    cfg,
    input  item_t   item,
    output result_t result
);

    mode_t              mode_reg, mode_next;
    logic [TIME_W-1:0]  mark_time_reg, mark_time_next;
    logic [COUNT_W-1:0] press_index_reg, press_index_next;
    logic [CODE_W-1:0]  press_pattern_reg, press_pattern_next;
    logic [CODE_W-1:0]  pending_code_reg, pending_code_next;
    logic [CODE_W-1:0]  code_now;

    logic [TIME_W-1:0] diff;
    logic              pressed;
    logic              deb_done;
    logic              short_done;
    logic              vlong_done;
    logic              gap_done;

    assign diff       = item.now_ms - mark_time_reg;
    assign pressed    = cfg.press_pol ? item.pin_level : !item.pin_level;
    assign deb_done   = diff > {{(TIME_W-LIMIT_W){1'b0}}, cfg.debounce_ms};
    assign short_done = diff > {{(TIME_W-LIMIT_W){1'b0}}, cfg.short_press_ms};
    assign vlong_done = diff > {{(TIME_W-LIMIT_W){1'b0}}, cfg.very_long_press_ms};
    assign gap_done   = diff > {{(TIME_W-LIMIT_W){1'b0}}, cfg.fire_gap_ms};

    always_comb begin
        mode_next          = mode_reg;
        mark_time_next     = mark_time_reg;
        press_index_next   = press_index_reg;
        press_pattern_next = press_pattern_reg;
        code_now           = pending_code_reg;
        case (mode_reg)
            MODE_WAIT: begin
                if (pressed) begin
                    mode_next          = MODE_DEB_DOWN;
                    mark_time_next     = item.now_ms;
                    press_index_next   = '1;
                    press_pattern_next = '0;
                end
            end
            MODE_DEB_DOWN: begin
                if (deb_done) begin
                    if (pressed) begin
                        mode_next        = MODE_HELD;
                        press_index_next = press_index_reg + COUNT_W'(1);
                    end else begin
                        mode_next = MODE_GAP;
                    end
                    mark_time_next = item.now_ms;
                end
            end
            MODE_HELD: begin
                if (!pressed) begin
                    if (vlong_done) begin
                        press_pattern_next = VERY_LONG_CODE;
                    end else begin
                        press_pattern_next = {press_pattern_reg[CODE_W-2:0], short_done};
                    end
                    mode_next      = MODE_DEB_UP;
                    mark_time_next = item.now_ms;
                end
            end
            MODE_DEB_UP: begin
                if (deb_done) begin
                    mode_next = (press_pattern_reg == VERY_LONG_CODE) ? MODE_VLONG : MODE_GAP;
                    mark_time_next = item.now_ms;
                end
            end
            MODE_GAP: begin
                if (pressed) begin
                    mode_next      = MODE_DEB_DOWN;
                    mark_time_next = item.now_ms;
                end else if (gap_done) begin
                    code_now  = {press_index_reg + COUNT_W'(1), {COUNT_SHIFT{1'b0}}}
                                + press_pattern_reg;
                    mode_next = MODE_WAIT;
                end
            end
            MODE_VLONG: begin
                code_now  = VERY_LONG_CODE;
                mode_next = MODE_WAIT;
            end
            default: begin
                mode_next = MODE_WAIT;
            end
        endcase
        pending_code_next = item.take_value ? '0 : code_now;
    end

    assign result.fired    = (code_now != '0);
    assign result.key_code = code_now;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg          <= MODE_WAIT;
            mark_time_reg     <= '0;
            press_index_reg   <= '1;
            press_pattern_reg <= '0;
            pending_code_reg  <= '0;
        end else if (en) begin
            mode_reg          <= mode_next;
            mark_time_reg     <= mark_time_next;
            press_index_reg   <= press_index_next;
            press_pattern_reg <= press_pattern_next;
            pending_code_reg  <= pending_code_next;
        end
    end

    `MPKD_ASSERT_NEXT(a_take_clears, en && item.take_value, pending_code_reg == '0, "code not cleared by take")
    `MPKD_ASSERT(a_vlong_pattern, (mode_reg != MODE_VLONG) || (press_pattern_reg == VERY_LONG_CODE), "very long state without full pattern")
    `MPKD_ASSERT(a_mode_onehot, $onehot(mode_reg), "mode register not one-hot")

endmodule

>>> hdl/multi_press_key_decoder.sv
`timescale 1ns / 1ps
// Path: a request is registered in stage 1 when accepted; its result is
// registered in the output stage that drives m_tdata. Throughput: 1 request
// per cycle unless m_tready stalls; one debounce/press state machine update per request.
// Reset: synchronous, active low; clears the state machine, both pipeline
// valids and restores the default timing registers.
`include "multi_press_key_decoder_defines.svh"
module multi_press_key_decoder
    import mpkd_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [IDX_W-1:0]      cfg_index,
    input  logic [LIMIT_W-1:0]    cfg_wdata,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // pin_level, now_ms[31:0], take_value, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // fired, key_code[7:0], zero pad
);

    cfg_t    cfg_reg;
    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t core_result;
    logic    s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.press_pol          <= 1'b0;
            cfg_reg.debounce_ms        <= DEBOUNCE_RST;
            cfg_reg.short_press_ms     <= SHORT_PRESS_RST;
            cfg_reg.very_long_press_ms <= VERY_LONG_RST;
            cfg_reg.fire_gap_ms        <= FIRE_GAP_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_PRESS_POL:   cfg_reg.press_pol          <= cfg_wdata[0];
                REG_DEBOUNCE:    cfg_reg.debounce_ms        <= cfg_wdata;
                REG_SHORT_PRESS: cfg_reg.short_press_ms     <= cfg_wdata;
                REG_VERY_LONG:   cfg_reg.very_long_press_ms <= cfg_wdata;
                REG_FIRE_GAP:    cfg_reg.fire_gap_ms        <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            s1_item_reg.pin_level  <= s_tdata[0];
            s1_item_reg.now_ms     <= s_tdata[TIME_W:1];
            s1_item_reg.take_value <= s_tdata[TIME_W+1];
        end
    end

    mpkd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (s1_adv),
        .cfg     (cfg_reg),
        .item    (s1_item_reg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            out_result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-CODE_W-1){1'b0}}, out_result_reg.key_code,
                       out_result_reg.fired};

    `MPKD_ASSERT(a_fired_match, !m_tvalid || (m_tdata[0] == (m_tdata[CODE_W:1] != '0)), "fired disagrees with key code")
    `MPKD_ASSERT_NEXT(a_adv_fills_out, s1_adv, m_tvalid, "advanced request produced no result")
    `MPKD_ASSERT_NEXT(a_stage_kept, s1_valid_reg && !s1_adv, s1_valid_reg, "stalled request dropped")

endmodule

>>> sim/multi_press_key_decoder_test.sv
`timescale 1ns / 1ps
module multi_press_key_decoder_test;
    import mpkd_pkg::*;

    typedef struct packed {
        logic              pin;
        logic [TIME_W-1:0] now;
        logic              take;
        logic              typed;
        logic              fired;
        logic [CODE_W-1:0] code;
    } press_row_t;

    localparam int DIRECTED_N = 27;
    localparam int PHASE_ITEMS = 105;

    // default settings: low pin is a press, debounce 30, short 500, very long 3000, gap 500
    localparam press_row_t DIRECTED [DIRECTED_N] = '{
        '{1'b1, 32'd0,          1'b0, 1'b1, 1'b0, 8'h00},
        '{1'b0, 32'd100,        1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b0, 32'd120,        1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b0, 32'd131,        1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b1, 32'd200,        1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b1, 32'd231,        1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b1, 32'd732,        1'b0, 1'b1, 1'b1, 8'h20},
        '{1'b1, 32'd733,        1'b1, 1'b1, 1'b1, 8'h20},
        '{1'b1, 32'd734,        1'b0, 1'b1, 1'b0, 8'h00},
        '{1'b0, 32'd1000,       1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b0, 32'd1031,       1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b1, 32'd4100,       1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b1, 32'd4131,       1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b0, 32'd4132,       1'b1, 1'b1, 1'b1, 8'hFF},
        '{1'b1, 32'd4133,       1'b0, 1'b1, 1'b0, 8'h00},
        '{1'b0, 32'd5000,       1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b1, 32'd5031,       1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b1, 32'd5600,       1'b0, 1'b1, 1'b0, 8'h00},
        '{1'b0, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b0, 32'h0000_001F,  1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b1, 32'h0000_0300,  1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b1, 32'h0000_0320,  1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b0, 32'h0000_0330,  1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b0, 32'h0000_0350,  1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b1, 32'h0000_0360,  1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b1, 32'h0000_0380,  1'b0, 1'b0, 1'b0, 8'h00},
        '{1'b1, 32'h0000_0600,  1'b1, 1'b0, 1'b0, 8'h00}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [IDX_W-1:0]     cfg_index;
    logic [LIMIT_W-1:0]   cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    multi_press_key_decoder dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // decoder shadow state
    cfg_t              dec_cfg;
    mode_t             dec_mode;
    logic [TIME_W-1:0] dec_mark;
    logic [CODE_W-1:0] dec_index;
    logic [CODE_W-1:0] dec_pattern;
    logic [CODE_W-1:0] dec_pending;

    result_t           expected_reports[$];
    int                report_errors;
    int                results_seen;
    int                random_sent;
    logic [TIME_W-1:0] wall_ms;
    bit                hold_done;
    result_t           got_report;
    result_t           want_report;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                     input logic [LIMIT_W-1:0] limit);
        logic [TIME_W-1:0] diff;
        diff = now - dec_mark;
        return diff > TIME_W'(limit);
    endfunction

    function automatic result_t decode_step(input item_t req);
        logic              pressed;
        logic [CODE_W-1:0] count_bits;
        result_t           res;
        pressed = dec_cfg.press_pol ? req.pin_level : !req.pin_level;
        case (dec_mode)
            MODE_WAIT: begin
                if (pressed) begin
                    dec_mode    = MODE_DEB_DOWN;
                    dec_mark    = req.now_ms;
                    dec_index   = 8'hFF;
                    dec_pattern = '0;
                end
            end
            MODE_DEB_DOWN: begin
                if (elapsed(req.now_ms, dec_cfg.debounce_ms)) begin
                    if (pressed) begin
                        dec_mode  = MODE_HELD;
                        dec_index = dec_index + 8'd1;
                    end else begin
                        dec_mode = MODE_GAP;
                    end
                    dec_mark = req.now_ms;
                end
            end
            MODE_HELD: begin
                if (!pressed) begin
                    dec_pattern = dec_pattern << 1;
                    if (elapsed(req.now_ms, dec_cfg.very_long_press_ms))
                        dec_pattern = VERY_LONG_CODE;
                    else if (elapsed(req.now_ms, dec_cfg.short_press_ms))
                        dec_pattern = dec_pattern + 8'd1;
                    dec_mode = MODE_DEB_UP;
                    dec_mark = req.now_ms;
                end
            end
            MODE_DEB_UP: begin
                if (elapsed(req.now_ms, dec_cfg.debounce_ms)) begin
                    dec_mode = (dec_pattern == VERY_LONG_CODE) ? MODE_VLONG : MODE_GAP;
                    dec_mark = req.now_ms;
                end
            end
            MODE_GAP: begin
                if (pressed) begin
                    dec_mode = MODE_DEB_DOWN;
                    dec_mark = req.now_ms;
                end else if (elapsed(req.now_ms, dec_cfg.fire_gap_ms)) begin
                    count_bits  = dec_index + 8'd1;
                    dec_pending = (count_bits << COUNT_SHIFT) + dec_pattern;
                    dec_mode    = MODE_WAIT;
                end
            end
            MODE_VLONG: begin
                dec_pending = VERY_LONG_CODE;
                dec_mode    = MODE_WAIT;
            end
            default: dec_mode = MODE_WAIT;
        endcase
        res.fired    = (dec_pending != '0);
        res.key_code = dec_pending;
        if (req.take_value)
            dec_pending = '0;
        return res;
    endfunction

    function automatic bit calm_stretch();
        return results_seen >= 500 && results_seen < 650;
    endfunction

    // caller is at a falling edge; returns at the falling edge after acceptance
    task automatic send_request(input item_t req, input bit typed, input result_t typed_res);
        result_t predicted;
        if (!calm_stretch() && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(req);
        do @(posedge aclk); while (!s_tready);
        predicted = decode_step(req);
        expected_reports.push_back(typed ? typed_res : predicted);
        @(negedge aclk);
    endtask

    task automatic emit(input logic level, input logic [TIME_W-1:0] t);
        item_t req;
        req.pin_level  = level;
        req.now_ms     = t;
        req.take_value = ($urandom_range(0, 3) == 0);
        send_request(req, 1'b0, '0);
        random_sent++;
    endtask

    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apply_settings(input logic act, input logic [LIMIT_W-1:0] deb,
                                  input logic [LIMIT_W-1:0] shrt,
                                  input logic [LIMIT_W-1:0] vlong,
                                  input logic [LIMIT_W-1:0] gap);
        logic [IDX_W-1:0]   regs [5];
        logic [LIMIT_W-1:0] vals [5];
        regs = '{REG_PRESS_POL, REG_DEBOUNCE, REG_SHORT_PRESS, REG_VERY_LONG, REG_FIRE_GAP};
        vals = '{LIMIT_W'(act), deb, shrt, vlong, gap};
        drain_block();
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            case (regs[i])
                REG_PRESS_POL:   dec_cfg.press_pol          = vals[i][0];
                REG_DEBOUNCE:    dec_cfg.debounce_ms        = vals[i];
                REG_SHORT_PRESS: dec_cfg.short_press_ms     = vals[i];
                REG_VERY_LONG:   dec_cfg.very_long_press_ms = vals[i];
                REG_FIRE_GAP:    dec_cfg.fire_gap_ms        = vals[i];
                default: ;
            endcase
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
    endtask

    // below, at, just past or well past a threshold
    function automatic logic [TIME_W-1:0] pick_span(input logic [LIMIT_W-1:0] limit);
        case ($urandom_range(0, 5))
            0:       return TIME_W'(limit);
            1:       return TIME_W'(limit) + 1;
            2:       return TIME_W'($urandom_range(0, limit));
            5:       return TIME_W'(limit) + 1 + $urandom_range(0, 3000);
            default: return TIME_W'(limit) + 1 + $urandom_range(0, 200);
        endcase
    endfunction

    task automatic run_gesture();
        int                presses;
        logic              down;
        logic [TIME_W-1:0] t0;
        presses = $urandom_range(1, 9);
        down    = dec_cfg.press_pol;
        for (int p = 0; p < presses; p++) begin
            emit(down, wall_ms);
            t0 = wall_ms;
            repeat ($urandom_range(0, 2))
                emit(1'($urandom_range(0, 1)), t0 + $urandom_range(0, dec_cfg.debounce_ms));
            wall_ms = t0 + pick_span(dec_cfg.debounce_ms);
            emit(($urandom_range(0, 9) == 0) ? !down : down, wall_ms);
            if ($urandom_range(0, 1) == 0)
                emit(down, wall_ms + $urandom_range(0, dec_cfg.short_press_ms));
            wall_ms = wall_ms + pick_span($urandom_range(0, 1) ? dec_cfg.short_press_ms
                                                              : dec_cfg.very_long_press_ms);
            emit(!down, wall_ms);
            t0 = wall_ms;
            repeat ($urandom_range(0, 2))
                emit(1'($urandom_range(0, 1)), t0 + $urandom_range(0, dec_cfg.debounce_ms));
            wall_ms = t0 + pick_span(dec_cfg.debounce_ms);
            emit(!down, wall_ms);
            if (p == presses - 1) begin
                wall_ms = wall_ms + pick_span(dec_cfg.fire_gap_ms);
                emit(!down, wall_ms);
                wall_ms = wall_ms + dec_cfg.fire_gap_ms + 1;
                emit(!down, wall_ms);
            end else begin
                wall_ms = wall_ms + $urandom_range(0, dec_cfg.fire_gap_ms);
            end
        end
    endtask

    task automatic run_random_phase();
        int stop_at;
        stop_at = random_sent + PHASE_ITEMS;
        while (random_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                if ($urandom_range(0, 1) == 0)
                    wall_ms = $urandom();
                emit(1'($urandom_range(0, 1)), $urandom());
            end else begin
                run_gesture();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            got_report = result_t'(m_tdata[$bits(result_t)-1:0]);
            if (expected_reports.size() == 0) begin
                $display("%0t: key report with none expected, fired %0b key_code %02h",
                         $time, got_report.fired, got_report.key_code);
                report_errors++;
            end else begin
                want_report = expected_reports.pop_front();
                if (got_report.fired !== want_report.fired) begin
                    $display("%0t: fired mismatch, expected %0b actual %0b",
                             $time, want_report.fired, got_report.fired);
                    report_errors++;
                end
                if (got_report.key_code !== want_report.key_code) begin
                    $display("%0t: key_code mismatch, expected %02h actual %02h",
                             $time, want_report.key_code, got_report.key_code);
                    report_errors++;
                end
            end
        end
    end

    // result side: random stalls, one long hold-off
    initial begin
        m_tready  = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (!hold_done && results_seen >= 300) begin
                hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(negedge aclk);
            end else if (!calm_stretch() && $urandom_range(0, 99) < 8) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin
        #20_000_000;
        $display("multi_press_key_decoder_test: FAIL");
        $finish;
    end

    initial begin
        item_t   req;
        result_t typed_res;
        aclk          = 1'b0;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        report_errors = 0;
        results_seen  = 0;
        random_sent   = 0;
        wall_ms       = '0;
        dec_cfg       = '{1'b0, DEBOUNCE_RST, SHORT_PRESS_RST, VERY_LONG_RST, FIRE_GAP_RST};
        dec_mode      = MODE_WAIT;
        dec_mark      = '0;
        dec_index     = 8'hFF;
        dec_pattern   = '0;
        dec_pending   = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int i = 0; i < DIRECTED_N; i++) begin
            req.pin_level      = DIRECTED[i].pin;
            req.now_ms         = DIRECTED[i].now;
            req.take_value     = DIRECTED[i].take;
            typed_res.fired    = DIRECTED[i].fired;
            typed_res.key_code = DIRECTED[i].code;
            send_request(req, DIRECTED[i].typed, typed_res);
        end
        wall_ms = 32'h0000_1000;

        run_random_phase();
        apply_settings(1'b1, 16'd0, 16'd0, 16'd0, 16'd0);
        run_random_phase();
        apply_settings(1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random_phase();
        apply_settings(1'($urandom_range(0, 1)), 16'($urandom_range(0, 40)),
                       16'($urandom_range(40, 700)), 16'($urandom_range(700, 4000)),
                       16'($urandom_range(40, 700)));
        run_random_phase();
        drain_block();
        run_random_phase();
        apply_settings(1'($urandom_range(0, 1)), 16'($urandom()), 16'($urandom()),
                       16'($urandom()), 16'($urandom()));
        run_random_phase();

        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (report_errors == 0 && expected_reports.size() == 0) begin
            $display("multi_press_key_decoder_test: PASS");
        end else begin
            $display("multi_press_key_decoder_test: FAIL");
        end
        $finish;
    end

endmodule
